// ===== design/jets_pkg.sv =====
// Shared types and constants for the Julia escape-time sector block.
package jets_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int SLOPE_BITS    = 28;

    // Ray slopes tan(2pi/7), tan(4pi/7), tan(8pi/7) with SLOPE_BITS fraction bits
    localparam logic signed [31:0] SLOPE_A = 32'sd336607333;
    localparam logic signed [31:0] SLOPE_B = -32'sd1176092577;
    localparam logic signed [31:0] SLOPE_C = 32'sd129271702;

    localparam logic signed [31:0] C_REAL_RST = -32'sd2056235;
    localparam logic signed [31:0] C_IMAG_RST = 32'sd12496707;
    localparam logic [9:0]         MAX_IT_RST = 10'd50;

    typedef enum logic [1:0] {
        REG_C_REAL = 2'd0,
        REG_C_IMAG = 2'd1,
        REG_MAX_IT = 2'd2
    } t_reg;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_SQRE = 10'b0000000010,
        ST_SQIM = 10'b0000000100,
        ST_TEST = 10'b0000001000,
        ST_CROS = 10'b0000010000,
        ST_SLA  = 10'b0000100000,
        ST_SLB  = 10'b0001000000,
        ST_SLC  = 10'b0010000000,
        ST_CLAS = 10'b0100000000,
        ST_HOLD = 10'b1000000000
    } t_state;

    // Operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MOP_RE_RE = 3'd0,
        MOP_IM_IM = 3'd1,
        MOP_RE_IM = 3'd2,
        MOP_SA_RE = 3'd3,
        MOP_SB_RE = 3'd4,
        MOP_SC_RE = 3'd5
    } t_mop;

    typedef struct packed {
        logic in_ready;
        logic load;
        t_mop op;
        logic take_re2;
        logic take_im2;
        logic step;
        logic take_ga;
        logic take_gb;
        logic finish;
        logic fail;
        logic out_valid;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_ready;
        logic at_limit;
        logic escaped;
    } t_stat;

endpackage

// ===== design/jets_pt_if.sv =====
// Start-point channel: valid/ready handshake with the complex start value.
interface jets_pt_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_real;
    logic signed [31:0] start_imag;

    modport source (output valid, output start_real, output start_imag, input ready);
    modport sink   (input valid, input start_real, input start_imag, output ready);
endinterface

// ===== design/jets_res_if.sv =====
// Result channel: valid/ready handshake with the colour index.
interface jets_res_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] colour_index;

    modport source (output valid, output colour_index, input ready);
    modport sink   (input valid, input colour_index, output ready);
endinterface

// ===== design/jets_mul.sv =====
// Shared 32x32 signed multiplier with registered product.
module jets_mul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_prod
);

    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== design/jets_ctrl.sv =====
// Sequencer that schedules the shared multiplier over iterations and classification.
module jets_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  jets_pkg::t_stat i_stat,
    output jets_pkg::t_ctrl o_ctrl
);

    jets_pkg::t_state r_state;
    jets_pkg::t_state n_state;
    jets_pkg::t_ctrl  ctrl;

    always_comb begin
        n_state = r_state;
        ctrl    = '0;
        ctrl.op = jets_pkg::MOP_RE_RE;
        unique case (r_state)
            jets_pkg::ST_IDLE: begin
                ctrl.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    ctrl.load = 1'b1;
                    n_state   = jets_pkg::ST_SQRE;
                end
            end
            jets_pkg::ST_SQRE: begin
                ctrl.op = jets_pkg::MOP_RE_RE;
                n_state = jets_pkg::ST_SQIM;
            end
            jets_pkg::ST_SQIM: begin
                ctrl.op       = jets_pkg::MOP_IM_IM;
                ctrl.take_re2 = 1'b1;
                n_state       = jets_pkg::ST_TEST;
            end
            jets_pkg::ST_TEST: begin
                ctrl.op       = jets_pkg::MOP_RE_IM;
                ctrl.take_im2 = 1'b1;
                if (i_stat.at_limit) begin
                    ctrl.fail = 1'b1;
                    n_state   = jets_pkg::ST_HOLD;
                end else if (i_stat.escaped) begin
                    n_state = jets_pkg::ST_SLA;
                end else begin
                    n_state = jets_pkg::ST_CROS;
                end
            end
            jets_pkg::ST_CROS: begin
                ctrl.step = 1'b1;
                n_state   = jets_pkg::ST_SQRE;
            end
            jets_pkg::ST_SLA: begin
                ctrl.op = jets_pkg::MOP_SA_RE;
                n_state = jets_pkg::ST_SLB;
            end
            jets_pkg::ST_SLB: begin
                ctrl.op      = jets_pkg::MOP_SB_RE;
                ctrl.take_ga = 1'b1;
                n_state      = jets_pkg::ST_SLC;
            end
            jets_pkg::ST_SLC: begin
                ctrl.op      = jets_pkg::MOP_SC_RE;
                ctrl.take_gb = 1'b1;
                n_state      = jets_pkg::ST_CLAS;
            end
            jets_pkg::ST_CLAS: begin
                ctrl.finish = 1'b1;
                n_state     = jets_pkg::ST_HOLD;
            end
            jets_pkg::ST_HOLD: begin
                ctrl.out_valid = 1'b1;
                if (i_stat.out_ready) begin
                    n_state = jets_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jets_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jets_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ctrl = ctrl;

endmodule

// ===== design/julia_escape_time_ray_sector.sv =====
// Top level of the Julia escape-time block with three-sector ray colouring.
//
// One start point z is taken per transaction and iterated as z <- z*z + c in
// signed fixed point (FRAC_BITS fraction bits, Q8.24 by default) while
// |z|^2 < 36 and the count stays below max_iterations. An escaping point is
// placed in one of three sectors by comparing im against slope*re for the
// rays at tan(2pi/7), tan(4pi/7) and tan(8pi/7); with count n and sector s,
// j = 5n + s and the colour index is j + (j mod 3)*10. A bounded point gives
// -1. All products run through one 32x32 multiplier, one product per cycle:
// each iteration steps through re*re, im*im, the escape test with re*im
// issued, and the update of z. The block holds one item at a time: the
// start channel is ready only while idle, and the result stays registered
// until the result transaction completes. Configuration registers (c_real,
// c_imag, max_iterations) are written through the plain write port; the
// user must write them only while the block is idle, which the block itself
// does not enforce. Writes to index 3 are ignored.
module julia_escape_time_ray_sector #(
    parameter int FRAC_BITS = jets_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    jets_pt_if.sink     i_pt,
    jets_res_if.source  o_res
);

    // Escape bound 36 in the working fixed-point format
    localparam logic signed [64:0] BOUND = 65'sd36 <<< FRAC_BITS;

    // Saturate a wide intermediate to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Residue mod 3 of a small value (at most 6 in use)
    function automatic logic [1:0] mod3_small(input logic [2:0] v);
        case (v) inside
            3'd0, 3'd3, 3'd6: return 2'd0;
            3'd1, 3'd4:       return 2'd1;
            3'd2, 3'd5:       return 2'd2;
            default:          return 2'd0;
        endcase
    endfunction

    jets_pkg::t_ctrl ctrl;
    jets_pkg::t_stat stat;

    // Configuration registers
    logic signed [31:0] r_c_real;
    logic signed [31:0] r_c_imag;
    logic [9:0]         r_max_it;

    // Iteration state
    logic signed [31:0] r_re;
    logic signed [31:0] r_im;
    logic signed [63:0] r_re2;
    logic signed [63:0] r_im2;
    logic [9:0]         r_cnt;
    logic [1:0]         r_cm;     // r_cnt mod 3, tracked alongside the count
    logic               r_lt_a;
    logic               r_lt_b;
    logic               r_gt_b;
    logic [13:0]        r_colour;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] w_prod;
    logic signed [63:0] sq_sh;
    logic signed [63:0] x_sh;
    logic signed [64:0] sum_sq;
    logic signed [65:0] nre;
    logic signed [65:0] nim;
    logic signed [63:0] imw;
    logic               lt_c;
    logic [1:0]         sector;
    logic [12:0]        w_j;
    logic [1:0]         w_m;
    logic [13:0]        w_colour;

    jets_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    jets_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (w_prod)
    );

    // Select the multiplier operands for this step
    always_comb begin
        unique case (ctrl.op)
            jets_pkg::MOP_RE_RE: begin
                mul_a = r_re;
                mul_b = r_re;
            end
            jets_pkg::MOP_IM_IM: begin
                mul_a = r_im;
                mul_b = r_im;
            end
            jets_pkg::MOP_RE_IM: begin
                mul_a = r_re;
                mul_b = r_im;
            end
            jets_pkg::MOP_SA_RE: begin
                mul_a = jets_pkg::SLOPE_A;
                mul_b = r_re;
            end
            jets_pkg::MOP_SB_RE: begin
                mul_a = jets_pkg::SLOPE_B;
                mul_b = r_re;
            end
            jets_pkg::MOP_SC_RE: begin
                mul_a = jets_pkg::SLOPE_C;
                mul_b = r_re;
            end
            default: begin
                mul_a = r_re;
                mul_b = r_re;
            end
        endcase
    end

    // Squares drop FRAC_BITS, the cross term one bit less (doubles it)
    assign sq_sh  = w_prod >>> FRAC_BITS;
    assign x_sh   = w_prod >>> (FRAC_BITS - 1);
    assign sum_sq = 65'(r_re2) + 65'(sq_sh);
    assign nre    = 66'(r_re2) - 66'(r_im2) + 66'(r_c_real);
    assign nim    = 66'(x_sh) + 66'(r_c_imag);

    // im scaled to the slope format for the ray compares
    assign imw  = {{(64 - 32 - jets_pkg::SLOPE_BITS){r_im[31]}}, r_im,
                   {jets_pkg::SLOPE_BITS{1'b0}}};
    assign lt_c = w_prod < imw;

    // Strict compares: a point on a ray falls through to sector 0
    always_comb begin
        if (r_lt_a && r_lt_b) begin
            sector = 2'd1;
        end else if (r_gt_b && lt_c) begin
            sector = 2'd2;
        end else begin
            sector = 2'd0;
        end
    end

    assign w_j      = {1'b0, r_cnt, 2'b00} + 13'(r_cnt) + 13'(sector);
    assign w_m      = mod3_small({r_cm, 1'b0} + 3'(sector));
    assign w_colour = {1'b0, w_j} + 14'({w_m, 3'b000}) + 14'({w_m, 1'b0});

    assign stat.in_valid  = i_pt.valid;
    assign stat.out_ready = o_res.ready;
    assign stat.at_limit  = r_cnt >= r_max_it;
    assign stat.escaped   = sum_sq >= BOUND;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_real <= jets_pkg::C_REAL_RST;
            r_c_imag <= jets_pkg::C_IMAG_RST;
            r_max_it <= jets_pkg::MAX_IT_RST;
        end else if (i_cfg_we) begin
            unique case (jets_pkg::t_reg'(i_cfg_idx))
                jets_pkg::REG_C_REAL: r_c_real <= i_cfg_data;
                jets_pkg::REG_C_IMAG: r_c_imag <= i_cfg_data;
                jets_pkg::REG_MAX_IT: r_max_it <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Iteration counter and its residue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_cm  <= '0;
        end else if (ctrl.load) begin
            r_cnt <= '0;
            r_cm  <= '0;
        end else if (ctrl.step) begin
            r_cnt <= r_cnt + 10'd1;
            r_cm  <= (r_cm == 2'd2) ? 2'd0 : r_cm + 2'd1;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (ctrl.load) begin
            r_re <= i_pt.start_real;
            r_im <= i_pt.start_imag;
        end else if (ctrl.step) begin
            r_re <= sat32(nre);
            r_im <= sat32(nim);
        end
        if (ctrl.take_re2) begin
            r_re2 <= sq_sh;
        end
        if (ctrl.take_im2) begin
            r_im2 <= sq_sh;
        end
        if (ctrl.take_ga) begin
            r_lt_a <= w_prod < imw;
        end
        if (ctrl.take_gb) begin
            r_lt_b <= w_prod < imw;
            r_gt_b <= w_prod > imw;
        end
        if (ctrl.fail) begin
            r_colour <= '1;
        end else if (ctrl.finish) begin
            r_colour <= w_colour;
        end
    end

    assign i_pt.ready         = ctrl.in_ready;
    assign o_res.valid        = ctrl.out_valid;
    assign o_res.colour_index = r_colour;

    // An update step is only ever taken below the iteration limit
    a_step_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.step |-> (r_cnt < r_max_it))
        else $error("iteration step taken at or past the limit");

    // Never take a new point while a result is still offered
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_res.valid && i_pt.ready))
        else $error("input ready while result pending");

    // A bounded point reports -1
    a_fail_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.fail |=> (r_colour == 14'h3fff))
        else $error("bounded point did not report -1");

    // An escaping point reports a non-negative index
    a_escape_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.finish |=> !r_colour[13])
        else $error("escaped point reported a negative index");

endmodule

// ===== verif/tb_julia_escape_time_ray_sector.sv =====
// Testbench for julia_escape_time_ray_sector: directed and random start points checked against a predictor.
module tb_julia_escape_time_ray_sector;

    localparam int FRAC        = jets_pkg::FRAC_BITS_DEF;
    // A bounded point at the largest limit runs the full iteration count, plus the
    // long receiver hold-off; keep the watchdog well clear of both.
    localparam int WDOG_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 400;

    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE      = 32'sd16777216;   // 1.0 in Q8.24

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    jets_pt_if  pt_if ();
    jets_res_if res_if ();

    julia_escape_time_ray_sector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_if),
        .o_res      (res_if)
    );

    // Shadow copy of the configuration registers, updated on every write.
    logic signed [31:0] c_re_shadow;
    logic signed [31:0] c_im_shadow;
    logic [9:0]         it_limit_shadow;

    // Colour indices predicted for accepted start points, oldest first.
    logic signed [13:0] colour_q[$];

    int fail_cnt     = 0;
    int quiet_cycles = 0;
    int stall_left   = 0;
    bit idle_en      = 1'b0;
    bit hold_pending = 1'b0;
    bit hold_done    = 1'b0;

    always #1 i_clk = ~i_clk;

    // Clamp a wide intermediate to the 32-bit signed range.
    function automatic longint clip_word(input longint x);
        if (x > longint'(WORD_MAX))
            return longint'(WORD_MAX);
        if (x < longint'(WORD_MIN))
            return longint'(WORD_MIN);
        return x;
    endfunction

    // Iterate z <- z*z + c from the start point under the shadow configuration
    // and return the sector-coded colour index, or -1 if z stays bounded.
    function automatic logic signed [13:0] escape_colour(input logic signed [31:0] zr,
                                                         input logic signed [31:0] zi);
        longint re;
        longint im;
        longint re2;
        longint im2;
        longint nre;
        longint nim;
        longint imw;
        longint j;
        longint bound;
        int     n;
        re    = zr;
        im    = zi;
        bound = longint'(36) <<< FRAC;
        re2   = (re * re) >>> FRAC;
        im2   = (im * im) >>> FRAC;
        n     = 0;
        while (n < int'(it_limit_shadow) && (re2 + im2) < bound) begin
            // 2*re*im comes from shifting one bit less
            nim = ((re * im) >>> (FRAC - 1)) + longint'(c_im_shadow);
            nre = re2 - im2 + longint'(c_re_shadow);
            im  = clip_word(nim);
            re  = clip_word(nre);
            re2 = (re * re) >>> FRAC;
            im2 = (im * im) >>> FRAC;
            n++;
        end
        if (n >= int'(it_limit_shadow))
            return '1;
        // Strict comparisons: a point exactly on a ray drops through to sector 0.
        imw = im <<< jets_pkg::SLOPE_BITS;
        j   = longint'(n) * 5;
        if (longint'(jets_pkg::SLOPE_A) * re < imw && longint'(jets_pkg::SLOPE_B) * re < imw)
            j += 1;
        else if (longint'(jets_pkg::SLOPE_B) * re > imw
                 && longint'(jets_pkg::SLOPE_C) * re < imw)
            j += 2;
        j = j + (j % 3) * 10;
        return j[13:0];
    endfunction

    function automatic logic signed [31:0] near_origin(input int unsigned span);
        return int'($urandom_range(0, 2 * span)) - int'(span);
    endfunction

    task automatic report(input string what, input logic signed [13:0] got,
                          input logic signed [13:0] want);
        $display("MISMATCH %s: got %0d, predicted %0d at %0t", what, got, want, $time);
        fail_cnt++;
    endtask

    // Drive one start point and record its predicted colour once the
    // transaction completes. With idling on, the gap is sometimes placed
    // after the block has gone idle so that it actually delays the block.
    task automatic offer_point(input logic signed [31:0] zr, input logic signed [31:0] zi);
        if (idle_en && $urandom_range(0, 2) == 0) begin
            do @(posedge i_clk); while (!pt_if.ready);
            repeat ($urandom_range(0, 4)) @(posedge i_clk);
        end else begin
            @(posedge i_clk);
        end
        pt_if.valid      <= 1'b1;
        pt_if.start_real <= zr;
        pt_if.start_imag <= zi;
        do @(posedge i_clk); while (!pt_if.ready);
        colour_q.push_back(escape_colour(zr, zi));
        pt_if.valid <= 1'b0;
    endtask

    // Drain outstanding results, let the block settle, then write all three
    // registers on consecutive edges.
    task automatic write_config(input logic signed [31:0] cre, input logic signed [31:0] cim,
                                input logic [9:0] lim);
        while (colour_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= jets_pkg::REG_C_REAL;
        i_cfg_data <= cre;
        @(posedge i_clk);
        i_cfg_idx  <= jets_pkg::REG_C_IMAG;
        i_cfg_data <= cim;
        @(posedge i_clk);
        i_cfg_idx  <= jets_pkg::REG_MAX_IT;
        i_cfg_data <= {22'd0, lim};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        c_re_shadow     = cre;
        c_im_shadow     = cim;
        it_limit_shadow = lim;
    endtask

    // Reset configuration: field extremes, the escape radius edge, each
    // sector, and points lying exactly on each of the three rays.
    task automatic test_reset_defaults();
        offer_point(32'sd0, 32'sd0);
        offer_point(6 * ONE, 32'sd0);          // exactly on the escape radius
        offer_point(6 * ONE - 1, 32'sd0);      // one step inside it
        offer_point(WORD_MAX, WORD_MAX);
        offer_point(WORD_MIN, WORD_MIN);
        offer_point(WORD_MAX, WORD_MIN);
        offer_point(WORD_MIN, WORD_MAX);
        offer_point(WORD_MIN, 32'sd0);
        offer_point(32'sd0, WORD_MIN);
        offer_point(32'sd0, 7 * ONE);          // upper sector
        offer_point(-7 * ONE, -ONE);           // lower-left sector
        offer_point(16 * ONE, jets_pkg::SLOPE_A);     // on the tan(2pi/7) ray
        offer_point(16 * ONE, jets_pkg::SLOPE_B);     // on the tan(4pi/7) ray
        offer_point(-16 * ONE, -jets_pkg::SLOPE_C);   // on the tan(8pi/7) ray
    endtask

    // Extreme constants push the next z out of range in both directions.
    task automatic test_extreme_constants();
        write_config(WORD_MAX, WORD_MIN, 10'd1023);
        offer_point(5 * ONE, 32'sd0);          // real part clips high
        offer_point(3 * ONE, -3 * ONE);        // imaginary part clips low
        offer_point(32'sd0, 32'sd0);
        write_config(WORD_MIN, WORD_MAX, 10'd1);
        offer_point(32'sd0, 5 * ONE);
        offer_point(7 * ONE, 7 * ONE);
        offer_point(32'sd0, 32'sd0);
    endtask

    // A zero limit runs no iteration, so even an escaping point reads as bounded.
    task automatic test_zero_limit();
        write_config(jets_pkg::C_REAL_RST, jets_pkg::C_IMAG_RST, 10'd0);
        offer_point(32'sd0, 32'sd0);
        offer_point(7 * ONE, 32'sd0);
    endtask

    // c = 0 with the largest limit: orbits that stay put run the full count.
    task automatic test_long_orbits();
        write_config(32'sd0, 32'sd0, 10'd1023);
        offer_point(32'sd0, 32'sd0);
        offer_point(ONE, 32'sd0);
        offer_point(32'sd0, ONE);
        offer_point(ONE / 2, ONE / 2);
        offer_point(ONE + 16, 32'sd0);         // slow escape after many squarings
    endtask

    // Hold the result channel off while points keep coming so the block
    // backs up and stalls its start channel.
    task automatic test_backpressure();
        write_config(jets_pkg::C_REAL_RST, jets_pkg::C_IMAG_RST, jets_pkg::MAX_IT_RST);
        hold_pending <= 1'b1;
        repeat (12) offer_point(near_origin(2 * ONE), near_origin(2 * ONE));
    endtask

    // Random constant and limit, then mostly points near the set where the
    // orbits are long, with some full-range points mixed in.
    task automatic test_random_sweep(input int count, input bit with_idle);
        logic signed [31:0] cre;
        logic signed [31:0] cim;
        logic signed [31:0] zr;
        logic signed [31:0] zi;
        if ($urandom_range(0, 3) == 0) begin
            cre = $urandom;
            cim = $urandom;
        end else begin
            cre = near_origin(ONE);
            cim = near_origin(ONE);
        end
        write_config(cre, cim, 10'($urandom_range(1, 80)));
        idle_en = with_idle;
        repeat (count) begin
            if ($urandom_range(0, 3) == 0) begin
                zr = $urandom;
                zi = $urandom;
            end else begin
                zr = near_origin(2 * ONE);
                zi = near_origin(2 * ONE);
            end
            offer_point(zr, zi);
        end
    endtask

    // Result side: random short stalls, or one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left   <= 0;
        end else if (hold_pending && !hold_done) begin
            hold_done    <= 1'b1;
            stall_left   <= HOLD_CYCLES - 1;
            res_if.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left   <= $urandom_range(0, 4);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        logic signed [13:0] want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (colour_q.size() == 0) begin
                report("unexpected colour_index", res_if.colour_index, 14'sd0);
            end else begin
                want = colour_q.pop_front();
                if (res_if.colour_index !== want)
                    report("colour_index", res_if.colour_index, want);
            end
        end
    end

    // Abort if no transaction completes on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= jets_pkg::REG_C_REAL;
        i_cfg_data       <= 32'd0;
        pt_if.valid      <= 1'b0;
        pt_if.start_real <= 32'sd0;
        pt_if.start_imag <= 32'sd0;
        c_re_shadow      = jets_pkg::C_REAL_RST;
        c_im_shadow      = jets_pkg::C_IMAG_RST;
        it_limit_shadow  = jets_pkg::MAX_IT_RST;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_en = 1'b1;

        test_reset_defaults();
        test_extreme_constants();
        test_zero_limit();
        test_long_orbits();
        test_backpressure();
        repeat (4) test_random_sweep(340, 1'b1);
        // Final stretch runs flat out on both sides.
        test_random_sweep(260, 1'b0);

        while (colour_q.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
